FILE: src/reversible_rotating_queue_macros.svh
// Assertion helpers for the queue. Clock and reset are taken from the using module.
`ifndef REVERSIBLE_ROTATING_QUEUE_MACROS_SVH
`define REVERSIBLE_ROTATING_QUEUE_MACROS_SVH

// Same-cycle implication.
`define RRQ_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("queue check failed");

// Next-cycle implication.
`define RRQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("queue check failed");

`endif

FILE: src/rrq_pkg.sv
`default_nettype none

package rrq_pkg;

   localparam int DEPTH_DEFAULT      = 1024;
   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int AMT_W              = 32;

   typedef enum logic [1:0] {
      FUNC_PUSH    = 2'd0,
      FUNC_POP     = 2'd1,
      FUNC_REVERSE = 2'd2,
      FUNC_ROTATE  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

endpackage

`default_nettype wire

FILE: src/rrq_rem.sv
`default_nettype none

// Restoring remainder unit: one quotient bit per cycle, over all NUM_W dividend bits.
module rrq_rem #(
   parameter int NUM_W = 32,
   parameter int DEN_W = 11
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] numer,
   input  wire logic [DEN_W-1:0] denom,
   output logic                  done,
   output logic [DEN_W-1:0]      rem
);

   localparam int CNT_BITS = $clog2(NUM_W + 1);

   logic [NUM_W-1:0]    num_ff, num_in;
   logic [DEN_W-1:0]    den_ff, den_in;
   logic [DEN_W-1:0]    rem_ff, rem_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DEN_W:0]      trial;

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, num_ff[NUM_W-1]};
      if (start) begin
         num_in  = numer;
         den_in  = denom;
         rem_in  = '0;
         cnt_in  = CNT_BITS'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(trial - {1'b0, den_ff});
         end else begin
            rem_in = trial[DEN_W-1:0];
         end
         num_in = num_ff << 1;
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

`default_nettype wire

FILE: src/reversible_rotating_queue.sv
// Reversible rotating queue: a FIFO of DEPTH words with push, pop, reverse and rotate.
// Request channel req_*: req_func selects the operation, req_push_value carries the
// word for a push, req_rotate_amount the signed rotation for a rotate. A request
// transfers when req_valid is high and req_stall is low; one request is worked at a time.
// Response channel rsp_*: exactly one response per request, in order, with the popped
// word, its valid flag, a status code and the occupancy after the operation.
// Path from request transfer to response register: push, reverse and rotate on an
// empty queue go from execute straight to the response state; pop adds a synchronous
// memory read; rotate runs the bit-serial remainder unit, which reduces the rotation
// amount modulo the occupancy to steps, then moves each word with one memory read and
// one write back. Only after the response is registered does the next request transfer.
// While rsp_valid and rsp_stall are both high the response register holds; a finished
// result then waits and the queue takes no new request until it has moved out.
// Reset clears the occupancy, front pointer, direction flag and all handshake state;
// the word memory is not cleared and is only read at entries written before.
`default_nettype none

`include "reversible_rotating_queue_macros.svh"

module reversible_rotating_queue
   import rrq_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
   localparam int CNT_W     = $clog2(DEPTH + 1)
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [1:0]              req_func,
   input  wire logic [DATA_WIDTH-1:0]   req_push_value,
   input  wire logic signed [AMT_W-1:0] req_rotate_amount,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [DATA_WIDTH-1:0]        rsp_pop_value,
   output logic                         rsp_value_valid,
   output logic [1:0]                   rsp_status,
   output logic [CNT_W-1:0]             rsp_occupancy
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int S_W    = ADDR_W + 1;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_EXEC = 7'b0000010,
      S_POPW = 7'b0000100,
      S_DIV  = 7'b0001000,
      S_RRD  = 7'b0010000,
      S_RWR  = 7'b0100000,
      S_RESP = 7'b1000000
   } state_type;

   // physical slot of logical element k
   function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] front,
                                                 input logic              rev,
                                                 input logic [CNT_W-1:0]  k);
      logic [S_W-1:0] off;
      logic [S_W-1:0] sum;
      off = (k == CNT_W'(DEPTH)) ? '0 : S_W'(k);
      if (!rev) begin
         sum = {1'b0, front} + off;
         if (sum >= S_W'(DEPTH)) begin
            sum = sum - S_W'(DEPTH);
         end
      end else if ({1'b0, front} < off) begin
         sum = {1'b0, front} + S_W'(DEPTH) - off;
      end else begin
         sum = {1'b0, front} - off;
      end
      return sum[ADDR_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] step_front(input logic [ADDR_W-1:0] front,
                                                    input logic              up);
      logic [ADDR_W-1:0] nxt;
      if (up) begin
         nxt = (front == ADDR_W'(DEPTH - 1)) ? '0 : front + ADDR_W'(1);
      end else begin
         nxt = (front == '0) ? ADDR_W'(DEPTH - 1) : front - ADDR_W'(1);
      end
      return nxt;
   endfunction

   state_type               state_ff, state_in;
   logic [ADDR_W-1:0]       front_ff, front_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    rev_ff, rev_in;
   logic [CNT_W-1:0]        steps_ff, steps_in;
   logic                    back_ff, back_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   func_type                op_ff;
   logic [DATA_WIDTH-1:0]   val_ff;
   logic [AMT_W-1:0]        amt_ff;
   logic [DATA_WIDTH-1:0]   res_value_ff, res_value_in;
   logic                    res_vv_ff, res_vv_in;
   status_type              res_status_ff, res_status_in;
   logic [DATA_WIDTH-1:0]   rsp_pop_value_ff;
   logic                    rsp_value_valid_ff;
   status_type              rsp_status_ff;
   logic [CNT_W-1:0]        rsp_occupancy_ff;

   logic [DATA_WIDTH-1:0]   store_ff [DEPTH];
   logic [DATA_WIDTH-1:0]   rd_data_ff;
   logic                    mem_we;
   logic [ADDR_W-1:0]       mem_waddr;
   logic [DATA_WIDTH-1:0]   mem_wdata;
   logic                    mem_re;
   logic [ADDR_W-1:0]       mem_raddr;

   logic                    take_req;
   logic                    rsp_load;
   logic                    div_start;
   logic                    div_done;
   logic [CNT_W-1:0]        div_rem;
   logic [AMT_W-1:0]        amt_mag;

   assign take_req  = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign amt_mag   = amt_ff[AMT_W-1] ? (~amt_ff + AMT_W'(1)) : amt_ff;

   rrq_rem #(
      .NUM_W (AMT_W),
      .DEN_W (CNT_W)
   ) u_rem (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (amt_mag),
      .denom (count_ff),
      .done  (div_done),
      .rem   (div_rem)
   );

   always_comb begin
      state_in      = state_ff;
      front_in      = front_ff;
      count_in      = count_ff;
      rev_in        = rev_ff;
      steps_in      = steps_ff;
      back_in       = back_ff;
      res_value_in  = res_value_ff;
      res_vv_in     = res_vv_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_load      = 1'b0;
      div_start     = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = rd_data_ff;
      mem_re        = 1'b0;
      mem_raddr     = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_value_in  = '0;
            res_vv_in     = 1'b0;
            res_status_in = ST_OK;
            state_in      = S_RESP;
            case (op_ff)
               FUNC_PUSH: begin
                  if (count_ff == CNT_W'(DEPTH)) begin
                     res_status_in = ST_FULL;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = slot_of(front_ff, rev_ff, count_ff);
                     mem_wdata = val_ff;
                     count_in  = count_ff + CNT_W'(1);
                  end
               end
               FUNC_POP: begin
                  if (count_ff == '0) begin
                     res_status_in = ST_EMPTY;
                  end else begin
                     mem_re    = 1'b1;
                     mem_raddr = slot_of(front_ff, rev_ff, '0);
                     state_in  = S_POPW;
                  end
               end
               FUNC_REVERSE: begin
                  if (count_ff != '0) begin
                     front_in = slot_of(front_ff, rev_ff, count_ff - CNT_W'(1));
                  end
                  rev_in = !rev_ff;
               end
               FUNC_ROTATE: begin
                  if (count_ff != '0) begin
                     div_start = 1'b1;
                     state_in  = S_DIV;
                  end
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_POPW: begin
            res_value_in = rd_data_ff;
            res_vv_in    = 1'b1;
            front_in     = step_front(front_ff, !rev_ff);
            count_in     = count_ff - CNT_W'(1);
            state_in     = S_RESP;
         end
         S_DIV: begin
            if (div_done) begin
               steps_in = div_rem;
               back_in  = amt_ff[AMT_W-1];
               state_in = (div_rem == '0) ? S_RESP : S_RRD;
            end
         end
         S_RRD: begin
            mem_re    = 1'b1;
            mem_raddr = back_ff ? slot_of(front_ff, rev_ff, count_ff - CNT_W'(1))
                                : slot_of(front_ff, rev_ff, '0);
            state_in  = S_RWR;
         end
         S_RWR: begin
            // move one word across the wrap: front to back, or back to front
            mem_we = 1'b1;
            if (!back_ff) begin
               mem_waddr = slot_of(front_ff, rev_ff, count_ff);
               front_in  = step_front(front_ff, !rev_ff);
            end else begin
               front_in  = step_front(front_ff, rev_ff);
               mem_waddr = front_in;
            end
            steps_in = steps_ff - CNT_W'(1);
            state_in = (steps_ff == CNT_W'(1)) ? S_RESP : S_RRD;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_load     = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rev_ff       <= 1'b0;
         steps_ff     <= '0;
         back_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rev_ff       <= rev_in;
         steps_ff     <= steps_in;
         back_ff      <= back_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         op_ff  <= func_type'(req_func);
         val_ff <= req_push_value;
         amt_ff <= req_rotate_amount;
      end
      res_value_ff  <= res_value_in;
      res_vv_ff     <= res_vv_in;
      res_status_ff <= res_status_in;
      if (rsp_load) begin
         rsp_pop_value_ff   <= res_value_ff;
         rsp_value_valid_ff <= res_vv_ff;
         rsp_status_ff      <= res_status_ff;
         rsp_occupancy_ff   <= count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= store_ff[mem_raddr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pop_value   = rsp_pop_value_ff;
   assign rsp_value_valid = rsp_value_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_occupancy   = rsp_occupancy_ff;

   `RRQ_ASSERT_NEXT(a_pop_decrements, state_ff == S_POPW, count_ff == $past(count_ff) - CNT_W'(1))
   `RRQ_ASSERT_NEXT(a_rotate_keeps_count, state_ff == S_RWR, count_ff == $past(count_ff))
   `RRQ_ASSERT_NOW(a_div_done_in_div, div_done, state_ff == S_DIV)
   `RRQ_ASSERT_NOW(a_popped_is_ok, rsp_valid_ff && rsp_value_valid_ff, rsp_status_ff == ST_OK)

endmodule

`default_nettype wire

FILE: tb/reversible_rotating_queue_test.sv
`default_nettype none

module reversible_rotating_queue_test;
   import rrq_pkg::*;

   localparam int OCC_W      = $clog2(DEPTH_DEFAULT + 1);
   localparam int QUEUE_CAP  = 48;
   localparam int RAND_ITEMS = 100;
   localparam int FILL_POINT = 80;

   typedef struct packed {
      bit [31:0]      pop_value;
      bit             value_valid;
      status_type     status;
      bit [OCC_W-1:0] occupancy;
   } queue_result_t;

   typedef struct packed {
      func_type      func;
      bit [31:0]     word;
      bit [31:0]     amount;
      bit            typed;
      queue_result_t outcome;
   } directed_row_t;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [1:0]              req_func = FUNC_PUSH;
   logic [31:0]             req_push_value = '0;
   logic signed [AMT_W-1:0] req_rotate_amount = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [31:0]             rsp_pop_value;
   logic                    rsp_value_valid;
   logic [1:0]              rsp_status;
   logic [OCC_W-1:0]        rsp_occupancy;

   bit [31:0]     shadow_words[$];
   queue_result_t pending_results[$];
   int            fault_count = 0;
   int            stall_left = 0;
   bit            idle_on = 1'b1;
   bit            stall_on = 1'b1;
   directed_row_t stimulus_table [24];

   reversible_rotating_queue dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_push_value    (req_push_value),
      .req_rotate_amount (req_rotate_amount),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pop_value     (rsp_pop_value),
      .rsp_value_valid   (rsp_value_valid),
      .rsp_status        (rsp_status),
      .rsp_occupancy     (rsp_occupancy)
   );

   always #5 clock = ~clock;

   initial begin
      #50_000_000;
      $display("reversible_rotating_queue verification failed");
      $finish;
   end

   // Mostly no idling, some short gaps, a few long ones.
   function automatic int idle_cycles(input bit enabled);
      int p;
      p = $urandom_range(99);
      if (!enabled || p < 65) return 0;
      if (p < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic bit [31:0] random_amount(input int count);
      int p;
      int offset;
      p = $urandom_range(99);
      offset = int'($urandom_range(160)) - 80;
      if (p < 40) return offset;
      if (p < 60) return (int'($urandom_range(6)) - 3) * count;
      if (p < 85) return $urandom;
      case ($urandom_range(4))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0;
         default: return 32'h1;
      endcase
   endfunction

   // Apply one operation to the shadow queue, front of the queue at index 0.
   function automatic queue_result_t predict_outcome(input func_type f, input bit [31:0] word,
                                                      input bit [31:0] amount);
      queue_result_t res;
      bit [31:0]     held[$];
      longint        rem;
      res = '0;
      res.status = ST_OK;
      case (f)
         FUNC_PUSH: begin
            if (shadow_words.size() >= DEPTH_DEFAULT) res.status = ST_FULL;
            else shadow_words.push_back(word);
         end
         FUNC_POP: begin
            if (shadow_words.size() == 0) begin
               res.status = ST_EMPTY;
            end else begin
               res.pop_value = shadow_words.pop_front();
               res.value_valid = 1'b1;
            end
         end
         FUNC_REVERSE: begin
            held = shadow_words;
            shadow_words.delete();
            foreach (held[i]) shadow_words.push_front(held[i]);
         end
         default: begin
            if (shadow_words.size() != 0) begin
               // remainder keeps the sign of the amount
               rem = longint'($signed(amount)) % longint'(shadow_words.size());
               if (rem > 0) repeat (rem) shadow_words.push_back(shadow_words.pop_front());
               else repeat (-rem) shadow_words.push_front(shadow_words.pop_back());
            end
         end
      endcase
      res.occupancy = OCC_W'(shadow_words.size());
      return res;
   endfunction

   task automatic issue_op(input func_type f, input bit [31:0] word, input bit [31:0] amount,
                           input bit typed, input queue_result_t typed_outcome);
      int            gap;
      queue_result_t predicted;
      gap = idle_cycles(idle_on);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_push_value <= word;
      req_rotate_amount <= amount;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = predict_outcome(f, word, amount);
      pending_results.push_back(typed ? typed_outcome : predicted);
   endtask

   task automatic random_op(input int cap);
      int p;
      int n;
      p = $urandom_range(99);
      n = shadow_words.size();
      if (p < 38 && n < cap)
         issue_op(FUNC_PUSH, ($urandom_range(9) == 0) ? {32{p[0]}} : $urandom, $urandom, 1'b0,
                  '0);
      else if (p < 70)
         issue_op(FUNC_POP, $urandom, $urandom, 1'b0, '0);
      else if (p < 80)
         issue_op(FUNC_REVERSE, $urandom, $urandom, 1'b0, '0);
      else
         issue_op(FUNC_ROTATE, $urandom, random_amount(n), 1'b0, '0);
   endtask

   // Response side: check each transfer against the oldest expectation, then pick the stall.
   always @(posedge clock) begin
      queue_result_t want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $display("%0t: response with nothing outstanding, status %0d occupancy %0d",
                        $time, rsp_status, rsp_occupancy);
               fault_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_pop_value !== want.pop_value) begin
                  $display("%0t: pop_value expected %h, got %h", $time, want.pop_value,
                           rsp_pop_value);
                  fault_count++;
               end
               if (rsp_value_valid !== want.value_valid) begin
                  $display("%0t: value_valid expected %0d, got %0d", $time, want.value_valid,
                           rsp_value_valid);
                  fault_count++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d, got %0d", $time, want.status, rsp_status);
                  fault_count++;
               end
               if (rsp_occupancy !== want.occupancy) begin
                  $display("%0t: occupancy expected %0d, got %0d", $time, want.occupancy,
                           rsp_occupancy);
                  fault_count++;
               end
            end
         end
         if (stall_left == 0) stall_left = idle_cycles(stall_on);
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      stimulus_table = '{
         '{FUNC_POP,     32'h0,         32'h0,         1'b1, '{32'h0, 1'b0, ST_EMPTY, 11'd0}},
         '{FUNC_ROTATE,  32'h0,         32'd5,         1'b1, '{32'h0, 1'b0, ST_OK, 11'd0}},
         '{FUNC_REVERSE, 32'h0,         32'h0,         1'b1, '{32'h0, 1'b0, ST_OK, 11'd0}},
         '{FUNC_PUSH,    32'hFFFF_FFFF, 32'h0,         1'b1, '{32'h0, 1'b0, ST_OK, 11'd1}},
         '{FUNC_PUSH,    32'h0,         32'hFFFF_FFFF, 1'b1, '{32'h0, 1'b0, ST_OK, 11'd2}},
         '{FUNC_PUSH,    32'h1234_5678, 32'h0,         1'b1, '{32'h0, 1'b0, ST_OK, 11'd3}},
         '{FUNC_PUSH,    32'h8000_0001, 32'h0,         1'b1, '{32'h0, 1'b0, ST_OK, 11'd4}},
         '{FUNC_POP,     32'h0,         32'h0,         1'b1,
           '{32'hFFFF_FFFF, 1'b1, ST_OK, 11'd3}},
         '{FUNC_REVERSE, 32'h0,         32'h0,         1'b0, '0},
         '{FUNC_ROTATE,  32'h0,         32'h1,         1'b0, '0},
         '{FUNC_ROTATE,  32'h0,         32'hFFFF_FFFF, 1'b0, '0},
         '{FUNC_ROTATE,  32'h0,         32'h7FFF_FFFF, 1'b0, '0},
         '{FUNC_ROTATE,  32'h0,         32'h8000_0000, 1'b0, '0},
         '{FUNC_ROTATE,  32'h0,         32'd3,         1'b0, '0},
         '{FUNC_ROTATE,  32'h0,         32'hFFFF_FFFD, 1'b0, '0},
         '{FUNC_ROTATE,  32'h0,         32'hFFFF_FFFE, 1'b0, '0},
         '{FUNC_POP,     32'h0,         32'h0,         1'b0, '0},
         '{FUNC_POP,     32'h0,         32'h0,         1'b0, '0},
         '{FUNC_POP,     32'h0,         32'h0,         1'b0, '0},
         '{FUNC_POP,     32'h0,         32'h0,         1'b1, '{32'h0, 1'b0, ST_EMPTY, 11'd0}},
         '{FUNC_ROTATE,  32'h0,         32'h8000_0000, 1'b1, '{32'h0, 1'b0, ST_OK, 11'd0}},
         '{FUNC_PUSH,    32'hA5A5_A5A5, 32'h0,         1'b1, '{32'h0, 1'b0, ST_OK, 11'd1}},
         '{FUNC_ROTATE,  32'h0,         32'hFFFF_FFFF, 1'b1, '{32'h0, 1'b0, ST_OK, 11'd1}},
         '{FUNC_POP,     32'h0,         32'h0,         1'b1,
           '{32'hA5A5_A5A5, 1'b1, ST_OK, 11'd0}}
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (stimulus_table[i])
         issue_op(stimulus_table[i].func, stimulus_table[i].word, stimulus_table[i].amount,
                  stimulus_table[i].typed, stimulus_table[i].outcome);

      for (int k = 0; k < RAND_ITEMS; k++) begin
         // switch between quiet stretches and stretches with idling
         if (k % 25 == 0) begin
            idle_on = ($urandom_range(3) != 0);
            stall_on = ($urandom_range(3) != 0);
         end
         if (k == FILL_POINT) begin
            while (shadow_words.size() < DEPTH_DEFAULT)
               issue_op(FUNC_PUSH, $urandom, $urandom, 1'b0, '0);
            repeat (3) issue_op(FUNC_PUSH, $urandom, $urandom, 1'b0, '0);
            issue_op(FUNC_ROTATE, 0, $urandom, 1'b0, '0);
            issue_op(FUNC_ROTATE, 0, 32'h8000_0000, 1'b0, '0);
            issue_op(FUNC_ROTATE, 0, 32'hFFFF_FFFF, 1'b0, '0);
            issue_op(FUNC_ROTATE, 0, DEPTH_DEFAULT, 1'b0, '0);
            issue_op(FUNC_REVERSE, 0, 0, 1'b0, '0);
            issue_op(FUNC_ROTATE, 0, $urandom, 1'b0, '0);
            repeat (5) issue_op(FUNC_POP, 0, 0, 1'b0, '0);
            repeat (6) issue_op(FUNC_PUSH, $urandom, $urandom, 1'b0, '0);
         end
         random_op(QUEUE_CAP);
      end
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fault_count == 0) begin
         $display("reversible_rotating_queue verification clean");
      end else begin
         $display("reversible_rotating_queue verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
